// File: hw/rtl/channel_hit_rate_monitor_core_macros.svh
// Assertion macros shared by the monitor RTL.
`ifndef CHANNEL_HIT_RATE_MONITOR_CORE_MACROS_SVH
`define CHANNEL_HIT_RATE_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHRM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define CHRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/chrm_pkg.sv
package chrm_pkg;

   localparam int CHANNELS_PER_MODULE = 30;
   localparam int MAX_MODULES         = 16;
   localparam int SLOTS               = CHANNELS_PER_MODULE * MAX_MODULES;
   localparam int SLOT_W              = $clog2(SLOTS);
   localparam int SCAN_W              = $clog2(SLOTS + 1);
   localparam int MOD_IDX_W           = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
   localparam int MOD_CNT_W           = $clog2(MAX_MODULES + 1);
   localparam int CHAN_IDX_W          = $clog2(CHANNELS_PER_MODULE + 1);
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_IDX_W         = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W           = 2;

   localparam logic [15:0] WINDOW_MS_RESET     = 16'd2000;
   localparam logic [31:0] HOT_THRESHOLD_RESET = 32'd10000;
   localparam logic [31:0] MAX32               = 32'hFFFF_FFFF;
   localparam logic [8:0]  MAX9                = 9'h1FF;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_THRESHOLD = 2'd1;

   localparam logic CMD_HIT    = 1'b0;
   localparam logic CMD_HEADER = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [31:0] module_id;
      logic [4:0]  channel;
      logic [15:0] hit_count;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [31:0] total_hits;
      logic [8:0]  active_channels;
      logic [8:0]  odd_channels;
      logic [31:0] window_packets;
      logic [31:0] packets_total;
      logic [31:0] window_end_ms;
      logic [4:0]  modules_tracked;
      logic        overflow;
   } rsp_type;

   typedef enum logic {
      JOB_ADD,
      JOB_CLOSE
   } job_op_type;

   // One queued job for the counter engine.
   typedef struct packed {
      job_op_type           op;
      logic                 clr;
      logic                 add_en;
      logic [MOD_IDX_W-1:0] midx;
      logic [4:0]           chan;
      logic [15:0]          hits;
      logic [31:0]          window_packets;
      logic [31:0]          packets_total;
      logic [31:0]          end_ms;
      logic [MOD_CNT_W-1:0] mcount;
      logic                 overflow;
   } job_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] a);
      return (a == MAX32) ? a : a + 32'd1;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? MAX32 : s[31:0];
   endfunction

endpackage

// File: hw/rtl/chrm_front.sv
module chrm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  chrm_pkg::req_type   item,
   input  logic [15:0]         window_ms,
   output logic                push,
   output chrm_pkg::job_type   job
);
   import chrm_pkg::*;

   logic [31:0]          table_ff [MAX_MODULES];
   logic [MOD_CNT_W-1:0] count_ff;
   logic                 started_ff;
   logic [31:0]          ref_ff;
   logic [31:0]          wstart_ff;
   logic [31:0]          htotal_ff;
   logic [31:0]          hwindow_ff;
   logic                 ovf_ff;

   logic                 found;
   logic [MOD_IDX_W-1:0] found_idx;
   logic                 chan_ok;
   logic                 table_full;
   logic                 closes;
   logic [31:0]          elapsed;

   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int m = MAX_MODULES - 1; m >= 0; m--) begin
         if ((MOD_CNT_W'(m) < count_ff) && (table_ff[m] == item.module_id)) begin
            found     = 1'b1;
            found_idx = MOD_IDX_W'(m);
         end
      end
   end

   assign chan_ok    = CHAN_IDX_W'(item.channel) < CHAN_IDX_W'(CHANNELS_PER_MODULE);
   assign table_full = count_ff >= MOD_CNT_W'(MAX_MODULES);
   assign elapsed    = item.time_ms - wstart_ff;
   assign closes     = started_ff && (item.module_id == ref_ff) &&
                       (elapsed >= {16'd0, window_ms});

   always_comb begin
      push               = 1'b0;
      job                = '0;
      job.chan           = item.channel;
      job.hits           = item.hit_count;
      job.window_packets = hwindow_ff;
      job.packets_total  = htotal_ff;
      job.end_ms         = item.time_ms;
      job.mcount         = count_ff;
      job.overflow       = ovf_ff;
      if (accept) begin
         if (item.cmd == CMD_HIT) begin
            if (found) begin
               push       = chan_ok;
               job.op     = JOB_ADD;
               job.add_en = 1'b1;
               job.midx   = found_idx;
            end else if (!table_full) begin
               push       = 1'b1;
               job.op     = JOB_ADD;
               job.clr    = 1'b1;
               job.add_en = chan_ok;
               job.midx   = count_ff[MOD_IDX_W-1:0];
            end
         end else if (closes) begin
            push   = 1'b1;
            job.op = JOB_CLOSE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         started_ff <= 1'b0;
         ref_ff     <= '0;
         wstart_ff  <= '0;
         htotal_ff  <= '0;
         hwindow_ff <= '0;
         ovf_ff     <= 1'b0;
      end else if (accept) begin
         if (item.cmd == CMD_HIT) begin
            if (found) begin
               if (!chan_ok) ovf_ff <= 1'b1;
            end else if (table_full) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + MOD_CNT_W'(1);
               if (!chan_ok) ovf_ff <= 1'b1;
            end
         end else begin
            htotal_ff <= sat_inc(htotal_ff);
            if (!started_ff) begin
               started_ff <= 1'b1;
               ref_ff     <= item.module_id;
               wstart_ff  <= item.time_ms;
            end else if (closes) begin
               wstart_ff  <= item.time_ms;
               hwindow_ff <= '0;
            end else begin
               hwindow_ff <= sat_inc(hwindow_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (item.cmd == CMD_HIT) && !found && !table_full) begin
         table_ff[count_ff[MOD_IDX_W-1:0]] <= item.module_id;
      end
   end

endmodule

// File: hw/rtl/chrm_fifo.sv
`include "channel_hit_rate_monitor_core_macros.svh"

module chrm_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  chrm_pkg::job_type push_job,
   input  logic              pop,
   output chrm_pkg::job_type head,
   output logic              empty,
   output logic              full
);
   import chrm_pkg::*;

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] rd_ff;
   logic [QUEUE_IDX_W-1:0] wr_ff;
   logic [QUEUE_CNT_W-1:0] cnt_ff;

   assign head  = slot_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QUEUE_IDX_W'(1);
         if (pop)  rd_ff <= rd_ff + QUEUE_IDX_W'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + QUEUE_CNT_W'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

   `CHRM_ASSERT_NOW(a_no_push_full, clock, reset, push, !full)
   `CHRM_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !empty)
   `CHRM_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

// File: hw/rtl/chrm_back.sv
`include "channel_hit_rate_monitor_core_macros.svh"

module chrm_back (
   input  logic              clock,
   input  logic              reset,
   input  chrm_pkg::job_type head,
   input  logic              empty,
   input  logic [31:0]       hot_threshold,
   output logic              pop,
   output logic              rsp_valid,
   output chrm_pkg::rsp_type rsp
);
   import chrm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type              state_ff;
   job_type                cur_ff;
   logic [CHAN_IDX_W-1:0]  clr_ff;
   logic [SCAN_W-1:0]      idx_ff;
   logic                   pend_ff;
   logic [31:0]            total_ff;
   logic [8:0]             active_ff;
   logic [8:0]             odd_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [31:0]            mem [SLOTS];
   logic [31:0]            rd_ff;
   logic                   mem_we;
   logic [SLOT_W-1:0]      mem_wa;
   logic [31:0]            mem_wd;
   logic [SLOT_W-1:0]      mem_ra;

   logic [SLOT_W-1:0]      base;
   logic [SLOT_W-1:0]      add_addr;
   logic [SCAN_W-1:0]      limit;
   logic                   dispatch;
   logic [31:0]            total_in;
   logic [8:0]             active_in;
   logic [8:0]             odd_in;

   assign base     = SLOT_W'(cur_ff.midx) * SLOT_W'(CHANNELS_PER_MODULE);
   assign add_addr = base + SLOT_W'(cur_ff.chan);
   assign limit    = SCAN_W'(cur_ff.mcount) * SCAN_W'(CHANNELS_PER_MODULE);
   assign dispatch = (state_ff == ST_IDLE) || (state_ff == ST_ADD_WR);
   assign pop      = dispatch && !empty;

   always_comb begin
      total_in  = total_ff;
      active_in = active_ff;
      odd_in    = odd_ff;
      if (pend_ff) begin
         total_in = sat_add(total_ff, rd_ff);
         if ((rd_ff != '0) && (active_ff != MAX9))   active_in = active_ff + 9'd1;
         if ((rd_ff > hot_threshold) && (odd_ff != MAX9)) odd_in = odd_ff + 9'd1;
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = add_addr;
      mem_wd = '0;
      mem_ra = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = base + SLOT_W'(clr_ff);
         end
         ST_ADD_RD: mem_ra = add_addr;
         ST_ADD_WR: begin
            mem_we = 1'b1;
            mem_wd = sat_add(rd_ff, {16'd0, cur_ff.hits});
         end
         ST_SCAN: begin
            mem_ra = idx_ff[SLOT_W-1:0];
            mem_wa = idx_ff[SLOT_W-1:0];
            mem_we = (idx_ff < limit);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE, ST_ADD_WR: begin
               state_ff <= ST_IDLE;
               if (!empty) begin
                  cur_ff    <= head;
                  clr_ff    <= '0;
                  idx_ff    <= '0;
                  pend_ff   <= 1'b0;
                  total_ff  <= '0;
                  active_ff <= '0;
                  odd_ff    <= '0;
                  if (head.op == JOB_CLOSE) state_ff <= ST_SCAN;
                  else if (head.clr)        state_ff <= ST_CLEAR;
                  else                      state_ff <= ST_ADD_RD;
               end
            end
            ST_CLEAR: begin
               clr_ff <= clr_ff + CHAN_IDX_W'(1);
               if (clr_ff == CHAN_IDX_W'(CHANNELS_PER_MODULE - 1)) begin
                  state_ff <= cur_ff.add_en ? ST_ADD_RD : ST_IDLE;
               end
            end
            ST_ADD_RD: state_ff <= ST_ADD_WR;
            ST_SCAN: begin
               total_ff  <= total_in;
               active_ff <= active_in;
               odd_ff    <= odd_in;
               if (idx_ff < limit) begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff + SCAN_W'(1);
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               rsp_valid_ff           <= 1'b1;
               rsp_ff.total_hits      <= total_in;
               rsp_ff.active_channels <= active_in;
               rsp_ff.odd_channels    <= odd_in;
               rsp_ff.window_packets  <= cur_ff.window_packets;
               rsp_ff.packets_total   <= cur_ff.packets_total;
               rsp_ff.window_end_ms   <= cur_ff.end_ms;
               rsp_ff.modules_tracked <= 5'(cur_ff.mcount);
               rsp_ff.overflow        <= cur_ff.overflow;
               pend_ff                <= 1'b0;
               state_ff               <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `CHRM_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `CHRM_ASSERT_NOW(a_rsp_after_done, clock, reset, rsp_valid_ff, $past(state_ff == ST_DONE))
   `CHRM_ASSERT_NOW(a_wr_in_range, clock, reset, mem_we, mem_wa < SLOT_W'(SLOTS))

endmodule

// File: hw/rtl/channel_hit_rate_monitor_core.sv
// Channel     Ports                                  Beat accepted when
// ---------   ------------------------------------   ----------------------------
// request     start, busy, req_item                  start high and busy low
// response    rsp_valid, rsp_item                    rsp_valid high (one cycle)
// config      csr_we, csr_index, csr_wdata           csr_we high
//
// A packet header that does not close a window stays in the front end. A hit
// report passes the counter engine as a read, then a saturating write-back
// of the counter memory; a new module's first report first clears its 30
// counters. A window close scans enrolled_modules * 30 counters, one per cycle.
// Reset is synchronous; no clearing pass is needed, since a module's counters
// are zeroed when it enrolls. busy rises only while the four-entry job queue is
// full. The receiver cannot stall: each summary appears for exactly one cycle.
module channel_hit_rate_monitor_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  chrm_pkg::req_type                 req_item,
   output logic                              rsp_valid,
   output chrm_pkg::rsp_type                 rsp_item,
   input  logic                              csr_we,
   input  logic [chrm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);
   import chrm_pkg::*;

   // Configuration registers; the user must write them only while the block is quiet (not enforced here).
   logic [15:0] window_ms_ff;
   logic [31:0] hot_threshold_ff;

   logic    accept;
   logic    push;
   job_type push_job;
   logic    pop;
   job_type head;
   logic    empty;
   logic    full;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff     <= WINDOW_MS_RESET;
         hot_threshold_ff <= HOT_THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_MS:     window_ms_ff     <= csr_wdata[15:0];
            CSR_HOT_THRESHOLD: hot_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The front end keeps the module table and header bookkeeping, so it can
   // take a beat whenever the queue has room.
   assign busy   = full;
   assign accept = start && !busy;

   chrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_item),
      .window_ms (window_ms_ff),
      .push      (push),
      .job       (push_job)
   );

   chrm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   // The back end owns the counter memory and produces the summaries.
   chrm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .hot_threshold (hot_threshold_ff),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp           (rsp_item)
   );

endmodule

// File: sim/tb_channel_hit_rate_monitor_core.sv
module tb_channel_hit_rate_monitor_core;
   timeunit 1ns;
   timeprecision 1ps;

   import chrm_pkg::*;

   // After the last summary, queued hit reports may still be in the counter
   // engine. The four jobs that the queue holds fit well inside this pause.
   localparam int SETTLE_CYCLES = 200;
   // The longest silent stretch is a full scan of 480 counters plus queued
   // jobs and the largest sender gap, so this limit leaves a wide margin.
   localparam int STALL_LIMIT   = 5000;
   localparam int RANDOM_PER_PHASE = 110;
   localparam int PHASES        = 5;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   channel_hit_rate_monitor_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the monitor's state and registers.
   logic [15:0] win_ms;
   logic [31:0] hot_thr;
   logic [31:0] mod_ids [MAX_MODULES];
   int          mod_cnt;
   logic [31:0] chan_hits [SLOTS];
   bit          seen_header;
   logic [31:0] ref_id;
   logic [31:0] win_start;
   logic [31:0] hdr_total;
   logic [31:0] hdr_window;
   bit          sticky_ovf;

   rsp_type summary_q[$];
   int      errors;
   int      beats_sent;
   int      summaries_seen;
   int      stall_cycles;

   // Advances the shadow state by one accepted beat; returns whether it
   // closes a window and, if so, the summary it produces.
   task automatic advance_monitor(input req_type it, output bit closes, output rsp_type s);
      int m;
      int found;
      logic [32:0] sum;
      int active;
      int odd;
      closes = 1'b0;
      s = '0;
      if (it.cmd == CMD_HIT) begin
         found = -1;
         for (m = 0; m < mod_cnt; m++)
            if (found < 0 && mod_ids[m] == it.module_id) found = m;
         if (found < 0) begin
            if (mod_cnt >= MAX_MODULES) begin
               sticky_ovf = 1'b1;
               return;
            end
            found = mod_cnt;
            mod_ids[found] = it.module_id;
            for (m = 0; m < CHANNELS_PER_MODULE; m++)
               chan_hits[found * CHANNELS_PER_MODULE + m] = '0;
            mod_cnt++;
         end
         if (it.channel >= CHANNELS_PER_MODULE) begin
            sticky_ovf = 1'b1;
            return;
         end
         m = found * CHANNELS_PER_MODULE + it.channel;
         sum = {1'b0, chan_hits[m]} + {17'b0, it.hit_count};
         chan_hits[m] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         return;
      end
      if (!seen_header) begin
         seen_header = 1'b1;
         ref_id = it.module_id;
         win_start = it.time_ms;
         if (hdr_total != '1) hdr_total++;
         return;
      end
      if (it.module_id != ref_id || (it.time_ms - win_start) < {16'b0, win_ms}) begin
         if (hdr_total != '1) hdr_total++;
         if (hdr_window != '1) hdr_window++;
         return;
      end
      // The reference module closes the window: scan every enrolled counter.
      sum = '0;
      active = 0;
      odd = 0;
      for (m = 0; m < mod_cnt * CHANNELS_PER_MODULE; m++) begin
         sum = {1'b0, sum[31:0]} + {1'b0, chan_hits[m]};
         if (sum[32]) sum = {1'b0, 32'hFFFF_FFFF};
         if (chan_hits[m] != 0 && active < 511) active++;
         if (chan_hits[m] > hot_thr && odd < 511) odd++;
      end
      closes = 1'b1;
      s.total_hits = sum[31:0];
      s.active_channels = active[8:0];
      s.odd_channels = odd[8:0];
      s.window_packets = hdr_window;
      s.packets_total = hdr_total;
      s.window_end_ms = it.time_ms;
      s.modules_tracked = (mod_cnt > 31) ? 5'd31 : mod_cnt[4:0];
      s.overflow = sticky_ovf;
      win_start = it.time_ms;
      if (hdr_total != '1) hdr_total++;
      hdr_window = '0;
      for (m = 0; m < SLOTS; m++) chan_hits[m] = '0;
   endtask

   // Presents one beat after a random gap and waits until it is taken.
   // The predicted summary, or a hand-typed one when given, is queued.
   task automatic send_beat(input req_type it, input bit typed, input rsp_type typed_sum);
      int gap;
      bit closes;
      rsp_type s;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      advance_monitor(it, closes, s);
      beats_sent++;
      if (typed) begin
         if (!closes) begin
            $error("directed row expects a summary the predictor does not close");
            errors++;
         end
         summary_q = {summary_q, typed_sum};
      end else if (closes) begin
         summary_q = {summary_q, s};
      end
   endtask

   // Lowers start, lets every queued job drain, then writes one register.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      start <= 1'b0;
      wait (summary_q.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WINDOW_MS) win_ms = value[15:0];
      else if (idx == CSR_HOT_THRESHOLD) hot_thr = value;
   endtask

   // Every summary is checked, field by field, against the oldest one queued.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         summaries_seen++;
         if (summary_q.size() == 0) begin
            $error("summary beat with none expected");
            errors++;
         end else begin
            want = summary_q.pop_front();
            if (rsp_item.total_hits !== want.total_hits) begin
               $error("total_hits: expected %0d, got %0d", want.total_hits, rsp_item.total_hits);
               errors++;
            end
            if (rsp_item.active_channels !== want.active_channels) begin
               $error("active_channels: expected %0d, got %0d",
                      want.active_channels, rsp_item.active_channels);
               errors++;
            end
            if (rsp_item.odd_channels !== want.odd_channels) begin
               $error("odd_channels: expected %0d, got %0d",
                      want.odd_channels, rsp_item.odd_channels);
               errors++;
            end
            if (rsp_item.window_packets !== want.window_packets) begin
               $error("window_packets: expected %0d, got %0d",
                      want.window_packets, rsp_item.window_packets);
               errors++;
            end
            if (rsp_item.packets_total !== want.packets_total) begin
               $error("packets_total: expected %0d, got %0d",
                      want.packets_total, rsp_item.packets_total);
               errors++;
            end
            if (rsp_item.window_end_ms !== want.window_end_ms) begin
               $error("window_end_ms: expected %0d, got %0d",
                      want.window_end_ms, rsp_item.window_end_ms);
               errors++;
            end
            if (rsp_item.modules_tracked !== want.modules_tracked) begin
               $error("modules_tracked: expected %0d, got %0d",
                      want.modules_tracked, rsp_item.modules_tracked);
               errors++;
            end
            if (rsp_item.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_item.overflow);
               errors++;
            end
         end
      end
   end

   // The watchdog counts cycles in which no beat of any kind moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_channel_hit_rate_monitor_core NOT OK");
            $finish;
         end
      end
   end

   typedef struct {
      req_type it;
      bit      typed;
      rsp_type sum;
   } stim_row_type;

   // Builds a random beat. Most headers come from the reference module with
   // time advancing by up to two windows plus two ms, so windows close often; the rest
   // are foreign headers, wild timestamps and reports from unknown modules.
   function automatic req_type random_beat(ref logic [31:0] id_pool[20], ref logic [31:0] now_ms);
      req_type it;
      int pick;
      it.cmd = 1'($urandom_range(0, 1));
      it.module_id = id_pool[$urandom_range(0, 19)];
      it.channel = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(30, 31))
                                                 : 5'($urandom_range(0, 29));
      it.hit_count = 16'($urandom);
      it.time_ms = $urandom;
      pick = $urandom_range(0, 9);
      if (it.cmd == CMD_HIT) begin
         if (pick == 0) it.module_id = $urandom;
         if (pick == 1) it.hit_count = 16'hFFFF;
      end else if (pick < 7) begin
         it.module_id = ref_id;
         now_ms = now_ms + $urandom_range(0, 2 * win_ms + 2);
         it.time_ms = now_ms;
      end else if (pick == 7) begin
         now_ms = $urandom;
         it.time_ms = now_ms;
      end
      return it;
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      logic [31:0] id_pool[20];
      logic [31:0] now_ms;
      logic [15:0] phase_win[PHASES];
      logic [31:0] phase_thr[PHASES];
      int i;
      int p;

      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      errors = 0;
      beats_sent = 0;
      summaries_seen = 0;
      stall_cycles = 0;
      win_ms = WINDOW_MS_RESET;
      hot_thr = HOT_THRESHOLD_RESET;
      mod_cnt = 0;
      for (i = 0; i < SLOTS; i++) chan_hits[i] = '0;
      seen_header = 1'b0;
      ref_id = '0;
      win_start = '0;
      hdr_total = '0;
      hdr_window = '0;
      sticky_ovf = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table, run with the reset settings (2000 ms, threshold 10000).
      // Module 0 takes a full-scale and a single hit, then a bad channel;
      // the all-ones module enrolls through a bad channel with zero hits.
      row = '{'0, 1'b0, '0};
      row.it = '{CMD_HIT, 32'h0, 5'd0, 16'hFFFF, 32'h0};            rows = {rows, row};
      row.it = '{CMD_HIT, 32'h0, 5'd29, 16'd1, 32'hFFFF_FFFF};      rows = {rows, row};
      row.it = '{CMD_HIT, 32'h0, 5'd30, 16'd5, 32'h0};              rows = {rows, row};
      row.it = '{CMD_HIT, 32'hFFFF_FFFF, 5'd31, 16'd0, 32'h0};      rows = {rows, row};
      // The first header picks module 0 as reference and gives no summary.
      row.it = '{CMD_HEADER, 32'h0, 5'd31, 16'hFFFF, 32'd100};      rows = {rows, row};
      // A foreign header and a reference header one ms short of the window.
      row.it = '{CMD_HEADER, 32'hFFFF_FFFF, 5'd0, 16'd0, 32'd5000}; rows = {rows, row};
      row.it = '{CMD_HEADER, 32'h0, 5'd0, 16'd0, 32'd2099};         rows = {rows, row};
      // Exactly one window later: the summary can be read straight off.
      row.it = '{CMD_HEADER, 32'h0, 5'd0, 16'd0, 32'd2100};
      row.typed = 1'b1;
      row.sum = '{32'd65536, 9'd2, 9'd1, 32'd2, 32'd3, 32'd2100, 5'd2, 1'b1};
      rows = {rows, row};
      // A timestamp that wraps past zero still counts as a long gap.
      row.it = '{CMD_HEADER, 32'h0, 5'd0, 16'd0, 32'd0};
      row.sum = '{32'd0, 9'd0, 9'd0, 32'd0, 32'd4, 32'd0, 5'd2, 1'b1};
      rows = {rows, row};
      row.typed = 1'b0;
      row.sum = '0;
      // Fill the module table to its limit; the last report finds it full.
      for (i = 1; i <= 15; i++) begin
         row.it = '{CMD_HIT, 32'h1000 + i, 5'(i), 16'(i * 997), 32'h0};
         rows = {rows, row};
      end
      row.it = '{CMD_HEADER, 32'h0, 5'd0, 16'd0, 32'd4000};         rows = {rows, row};

      foreach (rows[i]) send_beat(rows[i].it, rows[i].typed, rows[i].sum);

      // Each phase runs random traffic under one register setting, the
      // extremes and the zero window among them. Index two is not a register
      // and must leave the settings alone.
      phase_win = '{16'd1, 16'hFFFF, 16'd0, 16'd50, 16'd700};
      phase_thr = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd20000, 32'd1};
      now_ms = 32'd4000;
      for (p = 0; p < PHASES; p++) begin
         // A fresh pool per phase, since the table fills up and never empties.
         id_pool[0] = 32'h0;
         id_pool[1] = 32'hFFFF_FFFF;
         for (i = 2; i < 20; i++) id_pool[i] = $urandom;
         write_csr(CSR_WINDOW_MS, {16'($urandom_range(0, 65535)), phase_win[p]});
         write_csr(CSR_HOT_THRESHOLD, phase_thr[p]);
         if (p == 2) write_csr(2'd2, $urandom);
         for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_beat(random_beat(id_pool, now_ms), 1'b0, '0);
      end

      @(negedge clock);
      start <= 1'b0;
      wait (summary_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d beats under %0d register settings; %0d window summaries checked.",
               beats_sent, PHASES + 1, summaries_seen);
      if (errors == 0 && summary_q.size() == 0) begin
         $display("tb_channel_hit_rate_monitor_core OK");
      end else begin
         $display("tb_channel_hit_rate_monitor_core NOT OK");
      end
      $finish;
   end

endmodule
